@@ rtl/great_circle_distance_core_macros.svh @@
// assertion helpers shared by the core
`ifndef GREAT_CIRCLE_DISTANCE_CORE_MACROS_SVH
`define GREAT_CIRCLE_DISTANCE_CORE_MACROS_SVH

// condition holds in the same cycle
`define GCD_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds a fixed number of cycles later
`define GCD_ASSERT_AFTER(label, ante, n, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##(n) (cons)) \
        else $error(msg);

`endif

@@ rtl/gcd_pkg.sv @@
package gcd_pkg;

    // field widths
    localparam int LAT_W    = 24;
    localparam int LON_W    = 25;
    localparam int RADIUS_W = 16;
    localparam int DIST_W   = 16;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd6371;

    // q30 datapath word, with headroom for cordic growth
    localparam int Q_W    = 33;
    localparam int PROD_W = 2 * Q_W;
    typedef logic signed [Q_W-1:0] t_q30;

    typedef struct packed {
        t_q30 sn;
        t_q30 cs;
    } t_sincos;

    localparam t_q30 Q30_ONE     = 33'sd1073741824;
    localparam t_q30 GAIN_Q30    = 33'sd652032874;
    localparam t_q30 HALF_PI_Q30 = 33'sd1686629713;

    // degree to radian conversion
    localparam int PI_W = 30;
    localparam logic [PI_W-1:0] PI_Q28 = 30'd843314857;
    localparam int W_W  = 37;
    localparam int WL_W = 18;
    localparam int WH_W = W_W - WL_W;
    localparam int RECIP_W = 32;
    localparam logic [RECIP_W-1:0] RECIP_45 = 32'd3054198967;
    localparam int RECIP_45_SHIFT = 37;

    // square root
    localparam int ROOT_W = 31;
    localparam int SQ_W   = 62;
    localparam int RAD_W  = 63;

    // atan(2^-i) in q30
    localparam int MAX_STEPS = 32;
    localparam t_q30 ATAN_TAB [MAX_STEPS] = '{
        33'sd843314857, 33'sd497837829, 33'sd263043837, 33'sd133525159,
        33'sd67021687,  33'sd33543516,  33'sd16775851,  33'sd8388437,
        33'sd4194283,   33'sd2097149,   33'sd1048576,   33'sd524288,
        33'sd262144,    33'sd131072,    33'sd65536,     33'sd32768,
        33'sd16384,     33'sd8192,      33'sd4096,      33'sd2048,
        33'sd1024,      33'sd512,       33'sd256,       33'sd128,
        33'sd64,        33'sd32,        33'sd16,        33'sd8,
        33'sd4,         33'sd2,         33'sd1,         33'sd1
    };

endpackage

@@ rtl/gcd_sincos.sv @@
module gcd_sincos #(
    parameter int ANGLE_FRAC_BITS = 16,
    parameter int CORDIC_STEPS = 24,
    localparam int DEG_W = (ANGLE_FRAC_BITS + 9 > 27) ? ANGLE_FRAC_BITS + 9 : 27
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [DEG_W-1:0] i_deg,
    output logic                    o_valid,
    output gcd_pkg::t_sincos        o_sc
);
    import gcd_pkg::*;

    localparam logic [63:0] FULL    = 64'd360 << ANGLE_FRAC_BITS;
    localparam logic [63:0] HALF    = 64'd180 << ANGLE_FRAC_BITS;
    localparam logic [63:0] QUARTER = 64'd90 << ANGLE_FRAC_BITS;
    localparam logic [63:0] KMUL    = ((64'd1 << (DEG_W - 1)) + FULL - 64'd1) / FULL;
    localparam logic [63:0] OFFSET  = KMUL * FULL;
    localparam int U_W   = DEG_W + 1;
    localparam logic [63:0] RECIP = ((64'd1 << U_W) + FULL - 64'd1) / FULL;
    localparam int RC_W  = $clog2(RECIP + 64'd1);
    localparam int P_W   = U_W + RC_W;
    localparam int R_W   = DEG_W + 3;
    localparam int MAG_W = ANGLE_FRAC_BITS + 7;
    localparam int PP_W  = MAG_W + PI_W;
    localparam logic [63:0] D_HALF = 64'd45 << (ANGLE_FRAC_BITS - 1);
    localparam int PH_W  = WH_W + RECIP_W;
    localparam int PL_W  = WL_W + RECIP_W;
    localparam int SUM_W = PH_W + WL_W + 1;
    localparam int QP_W  = RECIP_W + 6;

    localparam logic signed [R_W-1:0] FULL_S    = R_W'(FULL);
    localparam logic signed [R_W-1:0] HALF_S    = R_W'(HALF);
    localparam logic signed [R_W-1:0] QUARTER_S = R_W'(QUARTER);

    logic [6:0]              r_vpre;
    logic [U_W-1:0]          r_u;
    logic [U_W-1:0]          r_u2;
    logic [P_W-1:0]          r_prod;
    logic signed [R_W-1:0]   r_rm;
    logic [MAG_W-1:0]        r_mag;
    logic                    r_neg4, r_flip4;
    logic [PP_W-1:0]         r_p;
    logic                    r_neg5, r_flip5;
    logic [W_W-1:0]          r_w6;
    logic [PH_W-1:0]         r_ph;
    logic [PL_W-1:0]         r_pl;
    logic                    r_neg6, r_flip6;
    logic [RECIP_W-1:0]      r_qe;
    logic [W_W-1:0]          r_w7;
    logic                    r_neg7, r_flip7;
    t_q30                    r_x [CORDIC_STEPS+1];
    t_q30                    r_y [CORDIC_STEPS+1];
    t_q30                    r_z [CORDIC_STEPS+1];
    logic                    r_cf [CORDIC_STEPS+1];
    logic [CORDIC_STEPS:0]   r_cv;
    logic                    r_ov;
    t_sincos                 r_sc;

    logic [RC_W-1:0]         s3_q;
    logic [R_W-1:0]          s3_qf;
    logic signed [R_W-1:0]   n_rm;
    logic signed [R_W-1:0]   s4_a, s4_b, s4_c, s4_abs;
    logic                    n_neg, n_flip;
    logic [PP_W-1:0]         s6_t;
    logic [W_W-1:0]          n_w;
    logic [SUM_W-1:0]        s7_sum;
    logic [QP_W-1:0]         s8_prod;
    logic [RECIP_W-1:0]      s8_q;
    t_q30                    s8_mag, n_z;

    // valid bits travel alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vpre <= '0;
            r_cv   <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_vpre <= {r_vpre[5:0], i_valid};
            r_cv   <= {r_cv[CORDIC_STEPS-1:0], r_vpre[6]};
            r_ov   <= r_cv[CORDIC_STEPS];
        end
    end

    // modulo 360 by reciprocal, then fold into one quadrant
    assign s3_q  = r_prod[P_W-1:U_W];
    assign s3_qf = R_W'(s3_q) * R_W'(FULL);
    assign n_rm  = signed'(R_W'(r_u2) - s3_qf);

    always_comb begin
        s4_a   = (r_rm < 0) ? r_rm + FULL_S : r_rm;
        s4_b   = (s4_a >= HALF_S) ? s4_a - FULL_S : s4_a;
        s4_c   = s4_b;
        n_flip = 1'b0;
        if (s4_b > QUARTER_S) begin
            s4_c   = s4_b - HALF_S;
            n_flip = 1'b1;
        end else if (s4_b < -QUARTER_S) begin
            s4_c   = s4_b + HALF_S;
            n_flip = 1'b1;
        end
        n_neg  = (s4_c < 0);
        s4_abs = n_neg ? -s4_c : s4_c;
    end

    // radians: round(mag * pi / (45 * 2^f)), divide by 45 via reciprocal
    assign s6_t   = r_p + PP_W'(D_HALF);
    assign n_w    = W_W'(s6_t >> ANGLE_FRAC_BITS);
    assign s7_sum = (SUM_W'(r_ph) << WL_W) + SUM_W'(r_pl);
    assign s8_prod = QP_W'(r_qe) * QP_W'(45);
    assign s8_q   = (s8_prod > QP_W'(r_w7)) ? r_qe - RECIP_W'(1) : r_qe;
    assign s8_mag = t_q30'({1'b0, s8_q});
    assign n_z    = r_neg7 ? -s8_mag : s8_mag;

    always_ff @(posedge i_clk) begin
        r_u     <= U_W'(64'(i_deg) + OFFSET);
        r_u2    <= r_u;
        r_prod  <= P_W'(r_u) * P_W'(RECIP);
        r_rm    <= n_rm;
        r_mag   <= s4_abs[MAG_W-1:0];
        r_neg4  <= n_neg;
        r_flip4 <= n_flip;
        r_p     <= PP_W'(r_mag) * PP_W'(PI_Q28);
        r_neg5  <= r_neg4;
        r_flip5 <= r_flip4;
        r_w6    <= n_w;
        r_ph    <= PH_W'(n_w[W_W-1:WL_W]) * PH_W'(RECIP_45);
        r_pl    <= PL_W'(n_w[WL_W-1:0]) * PL_W'(RECIP_45);
        r_neg6  <= r_neg5;
        r_flip6 <= r_flip5;
        r_qe    <= RECIP_W'(s7_sum >> RECIP_45_SHIFT);
        r_w7    <= r_w6;
        r_neg7  <= r_neg6;
        r_flip7 <= r_flip6;
        r_x[0]  <= GAIN_Q30;
        r_y[0]  <= '0;
        r_z[0]  <= n_z;
        r_cf[0] <= r_flip7;
    end

    // rotation cordic, one micro-rotation per stage
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
        t_q30 xs, ys;
        assign xs = r_x[k] >>> k;
        assign ys = r_y[k] >>> k;
        always_ff @(posedge i_clk) begin
            if (r_z[k] >= 0) begin
                r_x[k+1] <= r_x[k] - ys;
                r_y[k+1] <= r_y[k] + xs;
                r_z[k+1] <= r_z[k] - ATAN_TAB[k];
            end else begin
                r_x[k+1] <= r_x[k] + ys;
                r_y[k+1] <= r_y[k] - xs;
                r_z[k+1] <= r_z[k] + ATAN_TAB[k];
            end
            r_cf[k+1] <= r_cf[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sc.sn <= r_cf[CORDIC_STEPS] ? -r_y[CORDIC_STEPS] : r_y[CORDIC_STEPS];
        r_sc.cs <= r_cf[CORDIC_STEPS] ? -r_x[CORDIC_STEPS] : r_x[CORDIC_STEPS];
    end

    assign o_valid = r_ov;
    assign o_sc    = r_sc;

endmodule

@@ rtl/gcd_isqrt.sv @@
module gcd_isqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  gcd_pkg::t_q30             i_c,
    output logic                      o_valid,
    output gcd_pkg::t_q30             o_c,
    output logic [gcd_pkg::ROOT_W-1:0] o_root
);
    import gcd_pkg::*;

    t_q30               c_abs;
    logic [SQ_W-1:0]    r_sq;
    t_q30               r_c1;
    logic [1:0]         r_vpre;
    logic [RAD_W-1:0]   r_rem [ROOT_W+1];
    logic [ROOT_W-1:0]  r_q   [ROOT_W+1];
    t_q30               r_c   [ROOT_W+1];
    logic [ROOT_W-1:0]  r_v;

    assign c_abs = (i_c < 0) ? -i_c : i_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vpre <= '0;
            r_v    <= '0;
        end else begin
            r_vpre <= {r_vpre[0], i_valid};
            r_v    <= {r_v[ROOT_W-2:0], r_vpre[1]};
        end
    end

    // 1 - c*c in q60
    always_ff @(posedge i_clk) begin
        r_sq     <= SQ_W'(c_abs[ROOT_W-1:0]) * SQ_W'(c_abs[ROOT_W-1:0]);
        r_c1     <= i_c;
        r_rem[0] <= (RAD_W'(1) << 60) - RAD_W'(r_sq);
        r_q[0]   <= '0;
        r_c[0]   <= r_c1;
    end

    // one root bit per stage, msb first
    for (genvar k = 0; k < ROOT_W; k++) begin : g_bit
        localparam int BIT = ROOT_W - 1 - k;
        logic [RAD_W-1:0] trial;
        assign trial = (RAD_W'(r_q[k]) << (BIT + 1)) | (RAD_W'(1) << (2 * BIT));
        always_ff @(posedge i_clk) begin
            if (r_rem[k] >= trial) begin
                r_rem[k+1] <= r_rem[k] - trial;
                r_q[k+1]   <= r_q[k] | (ROOT_W'(1) << BIT);
            end else begin
                r_rem[k+1] <= r_rem[k];
                r_q[k+1]   <= r_q[k];
            end
            r_c[k+1] <= r_c[k];
        end
    end

    assign o_valid = r_v[ROOT_W-1];
    assign o_c     = r_c[ROOT_W];
    assign o_root  = r_q[ROOT_W];

endmodule

@@ rtl/gcd_acos.sv @@
module gcd_acos #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  gcd_pkg::t_q30               i_c,
    input  logic [gcd_pkg::ROOT_W-1:0]  i_root,
    input  logic [gcd_pkg::RADIUS_W-1:0] i_radius,
    output logic                        o_valid,
    output logic [gcd_pkg::DIST_W-1:0]  o_distance
);
    import gcd_pkg::*;

    localparam int ZP_W = 32;
    localparam int DP_W = RADIUS_W + ZP_W;

    t_q30                  r_x [CORDIC_STEPS+1];
    t_q30                  r_y [CORDIC_STEPS+1];
    t_q30                  r_z [CORDIC_STEPS+1];
    logic [CORDIC_STEPS:0] r_v;
    logic                  r_va, r_vb;
    logic [DP_W-1:0]       r_dp;
    logic [DIST_W-1:0]     r_dist;

    t_q30                  n_x, n_y, n_z;
    t_q30                  zf;
    logic [ZP_W-1:0]       zp;
    logic [DP_W:0]         dr;
    logic [DP_W-30:0]      dk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_v  <= {r_v[CORDIC_STEPS-1:0], i_valid};
            r_va <= r_v[CORDIC_STEPS];
            r_vb <= r_va;
        end
    end

    // negative cosine: turn the vector by a quarter turn first
    always_comb begin
        if (i_c < 0) begin
            n_x = t_q30'({2'b00, i_root});
            n_y = -i_c;
            n_z = HALF_PI_Q30;
        end else begin
            n_x = i_c;
            n_y = t_q30'({2'b00, i_root});
            n_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0] <= n_x;
        r_y[0] <= n_y;
        r_z[0] <= n_z;
    end

    // vectoring cordic, drives y towards zero
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
        t_q30 xs, ys;
        assign xs = r_x[k] >>> k;
        assign ys = r_y[k] >>> k;
        always_ff @(posedge i_clk) begin
            if (r_y[k] >= 0) begin
                r_x[k+1] <= r_x[k] + ys;
                r_y[k+1] <= r_y[k] - xs;
                r_z[k+1] <= r_z[k] + ATAN_TAB[k];
            end else begin
                r_x[k+1] <= r_x[k] - ys;
                r_y[k+1] <= r_y[k] + xs;
                r_z[k+1] <= r_z[k] - ATAN_TAB[k];
            end
        end
    end

    // scale by radius, round to km, saturate
    assign zf = r_z[CORDIC_STEPS];
    assign zp = (zf < 0) ? '0 : zf[ZP_W-1:0];
    assign dr = (DP_W + 1)'(r_dp) + ((DP_W + 1)'(1) << 29);
    assign dk = dr[DP_W:30];

    always_ff @(posedge i_clk) begin
        r_dp   <= DP_W'(i_radius) * DP_W'(zp);
        r_dist <= (|dk[DP_W-30:DIST_W]) ? '1 : dk[DIST_W-1:0];
    end

    assign o_valid    = r_vb;
    assign o_distance = r_dist;

endmodule

@@ rtl/great_circle_distance_core.sv @@
// great circle distance core, spherical law of cosines
//
// input items: pulse i_start with the two points on i_first_latitude,
// i_first_longitude, i_second_latitude and i_second_longitude (signed
// degrees with ANGLE_FRAC_BITS fraction bits). o_busy is always low, so an
// item is taken on every cycle that i_start is high.
// results: o_done is high for exactly one cycle with o_distance_km, in
// whole kilometres, saturating at 65535. results come out in input order.
// the path is three parallel sine/cosine pipelines of CORDIC_STEPS + 9
// stages, four product stages, a 33-stage square root and an arc cosine
// pipeline of CORDIC_STEPS + 3 stages. throughput is one item per cycle.
// radius: i_radius_we writes i_radius_wdata; it is meant to change only
// while no item is in flight. reset restores 6371 km and clears every
// valid bit, so items in flight at reset are dropped.
// the receiver cannot stall the core; each result is shown for one cycle.
`include "great_circle_distance_core_macros.svh"

module great_circle_distance_core #(
    parameter int ANGLE_FRAC_BITS = 16,
    parameter int CORDIC_STEPS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic signed [gcd_pkg::LAT_W-1:0]    i_first_latitude,
    input  logic signed [gcd_pkg::LON_W-1:0]    i_first_longitude,
    input  logic signed [gcd_pkg::LAT_W-1:0]    i_second_latitude,
    input  logic signed [gcd_pkg::LON_W-1:0]    i_second_longitude,
    input  logic                                i_radius_we,
    input  logic [gcd_pkg::RADIUS_W-1:0]        i_radius_wdata,
    output logic                                o_done,
    output logic [gcd_pkg::DIST_W-1:0]          o_distance_km
);
    import gcd_pkg::*;

    localparam int DEG_W = (ANGLE_FRAC_BITS + 9 > 27) ? ANGLE_FRAC_BITS + 9 : 27;
    localparam logic signed [DEG_W-1:0] QUARTER_S = DEG_W'(64'd90 << ANGLE_FRAC_BITS);
    localparam int LATENCY = 2 * CORDIC_STEPS + 49;
    localparam logic signed [Q_W:0] ONE_W = (Q_W + 1)'(Q30_ONE);

    // q30 product rounded half up
    function automatic t_q30 round_q30(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + (PROD_W'(1) <<< 29);
        return t_q30'(t >>> 30);
    endfunction

    logic [RADIUS_W-1:0]       r_radius;
    logic signed [DEG_W-1:0]   deg_a, deg_b, deg_c;
    logic                      v_a, v_b, v_c, sc_valid;
    t_sincos                   sc_a, sc_b, sc_c;

    logic [2:0]                r_tv;
    logic                      r_cv;
    logic signed [PROD_W-1:0]  r_m12, r_mc, r_m;
    t_q30                      r_cd, r_cd2, r_r12, r_rc, r_rc3, r_c;
    logic signed [Q_W:0]       sum_c;
    t_q30                      n_c;

    logic                      sq_valid;
    t_q30                      sq_c;
    logic [ROOT_W-1:0]         sq_root;

    // the core never holds off an item
    assign o_busy = 1'b0;

    // radius register, to be written by the user only while idle, unenforced
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_radius_we) begin
            r_radius <= i_radius_wdata;
        end
    end

    // colatitudes and longitude difference in scaled degrees
    assign deg_a = QUARTER_S - DEG_W'(i_first_latitude);
    assign deg_b = QUARTER_S - DEG_W'(i_second_latitude);
    assign deg_c = DEG_W'(i_first_longitude) - DEG_W'(i_second_longitude);

    gcd_sincos #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STEPS    (CORDIC_STEPS)
    ) u_sincos_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start),
        .i_deg   (deg_a),
        .o_valid (v_a),
        .o_sc    (sc_a)
    );

    gcd_sincos #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STEPS    (CORDIC_STEPS)
    ) u_sincos_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start),
        .i_deg   (deg_b),
        .o_valid (v_b),
        .o_sc    (sc_b)
    );

    gcd_sincos #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STEPS    (CORDIC_STEPS)
    ) u_sincos_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start),
        .i_deg   (deg_c),
        .o_valid (v_c),
        .o_sc    (sc_c)
    );

    // the three lanes run in lockstep
    assign sc_valid = v_a & v_b & v_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv <= '0;
            r_cv <= 1'b0;
        end else begin
            r_tv <= {r_tv[1:0], sc_valid};
            r_cv <= r_tv[2];
        end
    end

    // c = round(round(s1*s2)*cd) + round(c1*c2), clamped to [-1, 1]
    assign sum_c = (Q_W + 1)'(round_q30(r_m)) + (Q_W + 1)'(r_rc3);

    always_comb begin
        if (sum_c > ONE_W) begin
            n_c = Q30_ONE;
        end else if (sum_c < -ONE_W) begin
            n_c = -Q30_ONE;
        end else begin
            n_c = t_q30'(sum_c);
        end
    end

    always_ff @(posedge i_clk) begin
        r_m12 <= PROD_W'(sc_a.sn) * PROD_W'(sc_b.sn);
        r_mc  <= PROD_W'(sc_a.cs) * PROD_W'(sc_b.cs);
        r_cd  <= sc_c.cs;
        r_r12 <= round_q30(r_m12);
        r_rc  <= round_q30(r_mc);
        r_cd2 <= r_cd;
        r_m   <= PROD_W'(r_r12) * PROD_W'(r_cd2);
        r_rc3 <= r_rc;
        r_c   <= n_c;
    end

    // sine of the central angle
    gcd_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_cv),
        .i_c     (r_c),
        .o_valid (sq_valid),
        .o_c     (sq_c),
        .o_root  (sq_root)
    );

    // central angle and scaling to km
    gcd_acos #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_acos (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (sq_valid),
        .i_c        (sq_c),
        .i_root     (sq_root),
        .i_radius   (r_radius),
        .o_valid    (o_done),
        .o_distance (o_distance_km)
    );

    `GCD_ASSERT_AFTER(a_done_after_start, i_start, LATENCY, o_done, "item lost in pipeline")
    `GCD_ASSERT_AFTER(a_no_stray_done, !i_start, LATENCY, !o_done, "result without an item")
    `GCD_ASSERT_IMPLIES(a_c_clamped, r_cv, (r_c <= Q30_ONE) && (r_c >= -Q30_ONE), "c not clamped")

endmodule

@@ tb/sv/tb_great_circle_distance_core.sv @@
module tb_great_circle_distance_core;
    import gcd_pkg::*;

    // drain time after the last item, a little above the pipeline depth
    localparam int PIPE_CYCLES = 2 * 24 + 49;
    localparam int DRAIN_CYCLES = PIPE_CYCLES + 40;
    // cycles with nothing accepted before the run is given up
    localparam int STALL_LIMIT = 4000;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int NUM_PHASES = 6;
    localparam int NUM_ROWS = 18;

    localparam longint Q30_UNIT = longint'(1) << 30;
    localparam longint PI_Q60 = 64'sh3243F6A8885A308D;
    localparam longint CORDIC_GAIN = 652032874;
    localparam longint DEG_UNIT = longint'(1) << 16;
    localparam int STEPS = 24;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_start;
    logic                    o_busy;
    logic signed [LAT_W-1:0] i_first_latitude;
    logic signed [LON_W-1:0] i_first_longitude;
    logic signed [LAT_W-1:0] i_second_latitude;
    logic signed [LON_W-1:0] i_second_longitude;
    logic                    i_radius_we;
    logic [RADIUS_W-1:0]     i_radius_wdata;
    logic                    o_done;
    logic [DIST_W-1:0]       o_distance_km;

    great_circle_distance_core DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (i_start),
        .o_busy             (o_busy),
        .i_first_latitude   (i_first_latitude),
        .i_first_longitude  (i_first_longitude),
        .i_second_latitude  (i_second_latitude),
        .i_second_longitude (i_second_longitude),
        .i_radius_we        (i_radius_we),
        .i_radius_wdata     (i_radius_wdata),
        .o_done             (o_done),
        .o_distance_km      (o_distance_km)
    );

    // 20 time unit clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // predictor state: the radius register and the atan(2^-i) table in q30
    longint unsigned radius_km;
    longint          atan_q30 [STEPS];

    // distances still owed by the core, oldest first
    logic [DIST_W-1:0] pending_km[$];
    int                fail_count;
    int                stall_cycles;
    int                items_sent;
    int                results_seen;
    bit                run_done;

    // table of atan(2^-i): taylor series in q60, pi/4 at i = 0, rounded to q30
    task automatic build_atan_q30();
        longint sum;
        longint term;
        int     e;
        for (int i = 0; i < STEPS; i++) begin
            sum = 0;
            if (i == 0) begin
                sum = PI_Q60 >>> 2;
            end else begin
                for (int k = 0; k < 64; k++) begin
                    e = 60 - (2 * k + 1) * i;
                    if (e < 0)
                        break;
                    term = (longint'(1) << e) / (2 * k + 1);
                    sum += (k % 2 == 1) ? -term : term;
                end
            end
            atan_q30[i] = (sum + (longint'(1) << 29)) >>> 30;
        end
    endtask

    function automatic longint q30_mul(longint a, longint b);
        return (a * b + (Q30_UNIT >>> 1)) >>> 30;
    endfunction

    // rotation cordic on an angle in scaled degrees, folded into +-90
    task automatic angle_sin_cos(input longint deg, output longint sn, output longint cs);
        longint          full;
        longint          half;
        longint          quarter;
        longint          r;
        longint          x;
        longint          y;
        longint          z;
        longint          xs;
        longint          ys;
        longint unsigned pi_q28;
        longint unsigned divisor;
        longint unsigned mag;
        bit              flip;
        full = 360 * DEG_UNIT;
        half = 180 * DEG_UNIT;
        quarter = 90 * DEG_UNIT;
        pi_q28 = (PI_Q60 + (longint'(1) << 31)) >>> 32;
        divisor = longint'(180) << 14;
        flip = 1'b0;
        r = deg % full;
        if (r < 0)
            r += full;
        if (r >= half)
            r -= full;
        // beyond a quarter turn: move by half a turn and negate both
        if (r > quarter) begin
            r -= half;
            flip = 1'b1;
        end else if (r < -quarter) begin
            r += half;
            flip = 1'b1;
        end
        mag = (r < 0) ? -r : r;
        z = (mag * pi_q28 + divisor / 2) / divisor;
        if (r < 0)
            z = -z;
        x = CORDIC_GAIN;
        y = 0;
        for (int i = 0; i < STEPS; i++) begin
            ys = y >>> i;
            xs = x >>> i;
            if (z >= 0) begin
                x -= ys;
                y += xs;
                z -= atan_q30[i];
            end else begin
                x += ys;
                y -= xs;
                z += atan_q30[i];
            end
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endtask

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = longint'(1) << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // law of cosines, arc cosine by vectoring cordic, then scale by the radius
    task automatic predict_distance(input logic signed [LAT_W-1:0] lat_a,
                                    input logic signed [LON_W-1:0] lon_a,
                                    input logic signed [LAT_W-1:0] lat_b,
                                    input logic signed [LON_W-1:0] lon_b,
                                    output logic [DIST_W-1:0] km);
        longint          s1, c1, s2, c2, sd, cd;
        longint          c;
        longint          x, y, z, xs, ys, t;
        longint unsigned dist_raw;
        angle_sin_cos(90 * DEG_UNIT - longint'(lat_a), s1, c1);
        angle_sin_cos(90 * DEG_UNIT - longint'(lat_b), s2, c2);
        angle_sin_cos(longint'(lon_a) - longint'(lon_b), sd, cd);
        c = q30_mul(q30_mul(s1, s2), cd) + q30_mul(c1, c2);
        if (c > Q30_UNIT)
            c = Q30_UNIT;
        if (c < -Q30_UNIT)
            c = -Q30_UNIT;
        y = floor_sqrt(Q30_UNIT * Q30_UNIT - c * c);
        x = c;
        z = 0;
        // negative cosine: turn the vector by -90 degrees first
        if (x < 0) begin
            t = x;
            x = y;
            y = -t;
            z = (PI_Q60 + (longint'(1) << 30)) >>> 31;
        end
        for (int i = 0; i < STEPS; i++) begin
            ys = y >>> i;
            xs = x >>> i;
            if (y >= 0) begin
                x += ys;
                y -= xs;
                z += atan_q30[i];
            end else begin
                x -= ys;
                y += xs;
                z -= atan_q30[i];
            end
        end
        if (z < 0)
            z = 0;
        dist_raw = (radius_km * longint'(z) + (longint'(1) << 29)) >> 30;
        km = (dist_raw > 65535) ? 16'hFFFF : dist_raw[DIST_W-1:0];
    endtask

    // one item: random idle cycles, then start held until taken
    task automatic send_item(input int idle_pct,
                             input logic signed [LAT_W-1:0] lat_a,
                             input logic signed [LON_W-1:0] lon_a,
                             input logic signed [LAT_W-1:0] lat_b,
                             input logic signed [LON_W-1:0] lon_b,
                             input int typed_km);
        logic [DIST_W-1:0] km;
        bit                taken;
        while ($urandom_range(99) < idle_pct) begin
            i_start = 1'b0;
            @(negedge i_clk);
        end
        i_start = 1'b1;
        i_first_latitude = lat_a;
        i_first_longitude = lon_a;
        i_second_latitude = lat_b;
        i_second_longitude = lon_b;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !o_busy;
            @(negedge i_clk);
        end
        if (typed_km >= 0)
            km = typed_km[DIST_W-1:0];
        else
            predict_distance(lat_a, lon_a, lat_b, lon_b, km);
        pending_km = {pending_km, km};
        items_sent++;
        i_start = 1'b0;
    endtask

    // radius writes only once every owed distance has come out
    task automatic write_radius(input logic [RADIUS_W-1:0] value);
        while (pending_km.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        i_radius_we = 1'b1;
        i_radius_wdata = value;
        @(negedge i_clk);
        i_radius_we = 1'b0;
        radius_km = value;
    endtask

    // random coordinate, mostly in range, sometimes any bit pattern
    function automatic logic signed [LAT_W-1:0] rand_lat();
        if ($urandom_range(9) == 0)
            return LAT_W'($urandom());
        return LAT_W'($signed($urandom_range(2 * 5898240)) - 5898240);
    endfunction

    function automatic logic signed [LON_W-1:0] rand_lon();
        if ($urandom_range(9) == 0)
            return LON_W'($urandom());
        return LON_W'($signed($urandom_range(2 * 11796480)) - 11796480);
    endfunction

    // result checker, results cannot be held off so each strobe is taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            results_seen++;
            if (pending_km.size() == 0) begin
                $error("distance_km: no item pending, actual %0d", o_distance_km);
                fail_count++;
            end else begin
                if (o_distance_km !== pending_km[0]) begin
                    $error("distance_km: expected %0d actual %0d",
                           pending_km[0], o_distance_km);
                    fail_count++;
                end
                void'(pending_km.pop_front());
            end
        end
    end

    // watchdog on cycles with neither an item taken nor a result seen
    always @(posedge i_clk) begin
        if (!run_done) begin
            if ((i_start && !o_busy) || o_done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // directed rows: lat a, lon a, lat b, lon b, typed km or -1 for the predictor
    typedef struct {
        int lat_a;
        int lon_a;
        int lat_b;
        int lon_b;
        int km;
    } t_route;

    t_route routes [NUM_ROWS];

    initial begin
        int idle_pct [NUM_PHASES];
        logic [RADIUS_W-1:0] radius_set [NUM_PHASES];
        logic signed [LAT_W-1:0] la, lb;
        logic signed [LON_W-1:0] oa, ob;
        int pick;

        routes = '{
            '{5898240, 0, -5898240, 0, 20015},          // pole to pole
            '{0, 0, 0, 5898240, 10008},                 // quarter of the equator
            '{0, 0, 0, 0, -1},                          // same point
            '{0, 0, 0, 11796480, -1},                   // antipodes on the equator
            '{0, -11796480, 0, 11796480, -1},           // longitude wraps a full turn
            '{5898240, 11796480, 5898240, -11796480, -1},
            '{-5898240, -11796480, -5898240, 11796480, -1},
            '{2949120, 655360, 2949121, 655360, -1},    // one lsb apart
            '{8388607, 16777215, -8388608, -16777216, -1}, // widest patterns
            '{-8388608, -16777216, 8388607, 16777215, -1},
            '{8388607, 0, 8388607, 0, -1},
            '{-8388608, 1, 3, -2, -1},
            '{5898239, 11796479, -5898239, -11796479, -1},
            '{3342336, -4718592, -2228224, 9240576, -1},
            '{1, 1, -1, -1, -1},
            '{-1, -1, -1, -1, -1},
            '{5898240, 123456, 5898240, -654321, -1},   // both at the north pole
            '{0, 5898240, 0, -5898240, -1}
        };
        idle_pct = '{0, 75, 0, 36, 75, 0};
        radius_set = '{16'd6371, 16'd65535, 16'd1, 16'd0, 16'd6371, 16'd6371};
        radius_set[4] = RADIUS_W'($urandom_range(2, 65534));

        fail_count = 0;
        stall_cycles = 0;
        items_sent = 0;
        results_seen = 0;
        run_done = 1'b0;
        radius_km = RADIUS_RESET;
        build_atan_q30();

        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_radius_we = 1'b0;
        i_radius_wdata = '0;
        i_first_latitude = '0;
        i_first_longitude = '0;
        i_second_latitude = '0;
        i_second_longitude = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed table at the reset radius
        foreach (routes[r])
            send_item(0, LAT_W'(routes[r].lat_a), LON_W'(routes[r].lon_a),
                      LAT_W'(routes[r].lat_b), LON_W'(routes[r].lon_b), routes[r].km);

        // random phases, each with a radius and idling percentage from a table
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0)
                write_radius(radius_set[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // a short run with no idling now and then
                pick = $urandom_range(9);
                la = rand_lat();
                oa = rand_lon();
                if (pick == 0) begin
                    lb = la;
                    ob = oa;
                end else if (pick == 1) begin
                    lb = -la;
                    ob = LON_W'(oa + 11796480);
                end else begin
                    lb = rand_lat();
                    ob = rand_lon();
                end
                send_item((n % 50 < 10) ? 0 : idle_pct[p], la, oa, lb, ob, -1);
            end
        end

        while (pending_km.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        run_done = 1'b1;

        $display("covered %0d items and %0d distances over %0d radius settings",
                 items_sent, results_seen, NUM_PHASES);
        $display("radii 6371, 65535, 1, 0 and %0d; sender idling 0, 36 and 75 percent",
                 radius_set[4]);
        if (fail_count == 0 && pending_km.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
